FILE: rtl/vhc_pkg.sv
package vhc_pkg;

  localparam int unsigned CounterBits = 9;

  typedef logic [CounterBits-1:0] count_t;

  typedef enum logic [2:0] {
    CfgMode5     = 3'd0,
    CfgV30       = 3'd1,
    CfgH40       = 3'd2,
    CfgInterlace = 3'd3,
    CfgPal       = 3'd4,
    CfgExtSync   = 3'd5,
    CfgHsyncEn   = 3'd6,
    CfgTestSel   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic   reset_request;
    logic   load_vertical;
    logic   load_horizontal;
    count_t load_value;
    logic   hsync_pin_in;
    logic   csync_pin_in;
    logic   ext_vertical_step;
    logic   ext_horizontal_step;
  } in_item_t;

  typedef struct packed {
    count_t hcount;
    count_t vcount;
    logic   odd_field;
    logic   vsync_out;
  } out_item_t;

endpackage

FILE: rtl/vhc_in_if.sv
interface vhc_in_if
  import vhc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/vhc_out_if.sv
interface vhc_out_if
  import vhc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/video_hv_counter_timing_unit.sv
// Dot counter for a video display processor: 9-bit horizontal and vertical
// counters, interlace field bit and vsync flag.
// Channels: in_i carries one item per dot tick (reset request, test loads,
// sync pin levels, external test steps); out_o returns one item per input
// item with the counters, field bit and vsync flag after that tick.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 mode5, 1 v30, 2 h40, 3 interlace, 4 pal, 5 ext sync, 6 hsync input
// enable, 7 test count select); write only while no item is in flight.
// Result: the result of an item is registered and valid on out_o in the cycle after accept.
// Throughput: one item per cycle while out_o is not stalled; the whole tick
// update is a single layer of compares and a 9-bit increment between the state
// registers and the result register.
// Stall: in_i.ready stays high while the result register is empty or being
// taken; if out_o is stalled the result holds and in_i.ready drops until
// the receiver takes it, so nothing is lost.
// Reset: rst_ni clears counters, flags, configuration and the result valid
// bit at once; there is no clearing pass.
module video_hv_counter_timing_unit
  import vhc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [1:0]      cfg_data_i,
  vhc_in_if.sink          in_i,
  vhc_out_if.source       out_o
);

  typedef struct packed {
    logic hmid;
    logic vsclr;
    logic vsset;
    logic vshclr;
    logic fieldset;
    logic vblank;
    logic hzero;
    logic vend;
    logic vstep;
    logic hend;
  } pos_match_t;

  // line compare target; en low means the line never matches
  typedef struct packed {
    logic   en;
    count_t line;
  } line_t;

  logic mode5_q, v30_q, h40_q, interlace_q, pal_q, ext_sync_q, hsync_en_q;
  logic [1:0] test_sel_q;

  count_t     hcount_q, hcount_d;
  count_t     vcount_q, vcount_d;
  logic       odd_q, odd_d;
  logic [1:0] sync_seen_q, sync_seen_d;
  logic [1:0] vsync_seen_q, vsync_seen_d;
  logic [1:0] hmark_q, hmark_d;
  logic [1:0] hmark_early_q, hmark_early_d;
  logic       hs_pin_q, cs_pin_q;
  pos_match_t pm_q, pm_d;
  logic       ftrig_q, ftrig_d;
  logic       vs_q, vs_d;

  logic      out_valid_q;
  out_item_t out_q;

  logic     accept;
  in_item_t it;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign it          = in_i.item;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  function automatic line_t mk_line(input logic en, input count_t line);
    line_t r;
    r.en   = en;
    r.line = line;
    return r;
  endfunction

  function automatic line_t line_vend(input logic pal, input logic m5, input logic v30,
                                      input logic il);
    line_t r;
    if (!pal) begin
      if (!m5)      r = mk_line(1'b1, 9'd218);
      else if (v30) r = mk_line(1'b0, 9'd0);
      else          r = mk_line(1'b1, 9'd234);
    end else if (!il) begin
      if (!m5)      r = mk_line(1'b1, 9'd242);
      else          r = mk_line(1'b1, v30 ? 9'd266 : 9'd258);
    end else begin
      r = mk_line(1'b1, v30 ? 9'd265 : 9'd257);
    end
    return r;
  endfunction

  function automatic line_t line_vshclr(input logic pal, input logic m5, input logic v30);
    line_t r;
    if (!pal) begin
      if (!m5)      r = mk_line(1'b1, 9'd485);
      else if (v30) r = mk_line(1'b0, 9'd0);
      else          r = mk_line(1'b1, 9'd501);
    end else begin
      if (!m5)      r = mk_line(1'b1, 9'd458);
      else          r = mk_line(1'b1, v30 ? 9'd482 : 9'd474);
    end
    return r;
  endfunction

  // vsync set/clear lines; clr selects the later (even base plus three) line
  function automatic line_t line_field(input logic clr, input logic odd, input logic pal,
                                       input logic m5, input logic v30);
    line_t  r;
    count_t base;
    if (!pal) begin
      if (!m5)      base = 9'd469;
      else          base = 9'd485;
    end else begin
      if (!m5)      base = 9'd442;
      else if (v30) base = 9'd466;
      else          base = 9'd458;
    end
    base = clr ? base + 9'd3 : base;
    if (!odd) begin
      r = mk_line(!(!pal && m5 && v30), base);
    end else if (!pal) begin
      r = mk_line(m5 && !v30, base - 9'd1);
    end else begin
      r = mk_line(m5, base - 9'd1);
    end
    return r;
  endfunction

  function automatic count_t v_reload(input logic pal, input logic m5, input logic v30);
    count_t r;
    if (!pal)     r = (m5 && !v30) ? 9'd485 : 9'd469;
    else if (!m5) r = 9'd442;
    else          r = v30 ? 9'd466 : 9'd458;
    return r;
  endfunction

  function automatic count_t h_reload(input logic es, input logic h40, input logic m5);
    count_t r;
    case ({es, h40, m5})
      3'd0:    r = 9'd466;
      3'd1:    r = 9'd466;
      3'd2:    r = 9'd464;
      3'd3:    r = 9'd457;
      3'd4:    r = 9'd468;
      3'd5:    r = 9'd476;
      default: r = 9'd464;
    endcase
    return r;
  endfunction

  logic  v_ext, v_rel, v_inc, h_ext, h_rel, h_inc;
  logic  sync_bit, gate, cs_hit, vbit, frame_top, f_toggle, f_clear;
  line_t vend_l, vshclr_l, vsset_l, vsclr_l;
  count_t vstep_col, vblank_line;

  always_comb begin
    v_ext = (vsync_seen_q == 2'b01) && ext_sync_q;
    v_rel = it.load_vertical || it.reset_request || (pm_q.vstep && pm_q.vend) || v_ext;
    v_inc = test_sel_q[0] ? it.ext_vertical_step : (pm_q.vstep && !v_rel);
    h_ext = (sync_seen_q == 2'b01) && ext_sync_q;
    h_rel = it.load_horizontal || it.reset_request || pm_q.hend || h_ext;
    h_inc = test_sel_q[1] ? it.ext_horizontal_step : !h_rel;

    sync_bit = ((hs_pin_q && hsync_en_q) || cs_pin_q || sync_seen_q[0])
               && !(hmark_q[0] || it.reset_request);
    sync_seen_d = {sync_seen_q[0], sync_bit};

    ftrig_d = ftrig_q;
    if (v_ext && hmark_early_q[1]) ftrig_d = 1'b1;
    if ((v_ext && hmark_q[1]) || it.reset_request) ftrig_d = 1'b0;

    gate = pm_q.hmid || !odd_q;
    vs_d = vs_q;
    if ((pm_q.vsset && gate) || it.reset_request) vs_d = 1'b1;
    if (pm_q.vsclr && gate) vs_d = 1'b0;

    cs_hit = (hmark_early_q[0] || hmark_q[0]) && cs_pin_q;
    vbit   = (vsync_seen_q[0] || cs_hit) && !pm_q.vshclr && !it.reset_request;
    vsync_seen_d = {vsync_seen_q[0], vbit};

    frame_top = pm_q.vblank && pm_q.hzero;
    f_toggle  = frame_top && !ext_sync_q;
    f_clear   = it.reset_request || !interlace_q || (!ftrig_d && frame_top && ext_sync_q);

    // position decodes from the counters before this tick, used one tick later
    vend_l      = line_vend(pal_q, mode5_q, v30_q, interlace_q);
    vshclr_l    = line_vshclr(pal_q, mode5_q, v30_q);
    vsset_l     = line_field(1'b0, odd_q, pal_q, mode5_q, v30_q);
    vsclr_l     = line_field(1'b1, odd_q, pal_q, mode5_q, v30_q);
    vstep_col   = mode5_q ? (h40_q ? 9'd328 : 9'd264) : 9'd488;
    vblank_line = mode5_q ? (v30_q ? 9'd240 : 9'd224) : 9'd192;

    pm_d.hend     = hcount_q == (h40_q ? 9'd363 : 9'd294);
    pm_d.vstep    = hcount_q == vstep_col;
    pm_d.vend     = vend_l.en && (vcount_q == vend_l.line);
    pm_d.hzero    = hcount_q == '0;
    pm_d.vblank   = vcount_q == vblank_line;
    pm_d.fieldset = frame_top && ext_sync_q && ftrig_d;
    pm_d.vshclr   = vshclr_l.en && (vcount_q == vshclr_l.line);
    pm_d.vsset    = vsset_l.en && (vcount_q == vsset_l.line);
    pm_d.vsclr    = vsclr_l.en && (vcount_q == vsclr_l.line);
    pm_d.hmid     = hcount_q == (h40_q ? 9'd120 : 9'd95);
    hmark_d       = {hmark_q[0], hcount_q == (h40_q ? 9'd253 : 9'd206)};
    hmark_early_d = {hmark_early_q[0], hcount_q == (h40_q ? 9'd43 : 9'd36)};

    if (v_rel) begin
      vcount_d = it.load_vertical ? it.load_value
                                  : v_reload(pal_q, mode5_q, v30_q) - count_t'(odd_q);
    end else if (v_inc) begin
      vcount_d = vcount_q + 9'd1;
    end else begin
      vcount_d = vcount_q;
    end

    if (h_rel) begin
      hcount_d = it.load_horizontal ? it.load_value : h_reload(ext_sync_q, h40_q, mode5_q);
    end else if (h_inc) begin
      hcount_d = hcount_q + 9'd1;
    end else begin
      hcount_d = hcount_q;
    end

    odd_d = odd_q;
    if (pm_q.fieldset) odd_d = 1'b1;
    if (f_toggle) odd_d = !odd_d;
    if (f_clear) odd_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode5_q     <= 1'b0;
      v30_q       <= 1'b0;
      h40_q       <= 1'b0;
      interlace_q <= 1'b0;
      pal_q       <= 1'b0;
      ext_sync_q  <= 1'b0;
      hsync_en_q  <= 1'b0;
      test_sel_q  <= 2'b00;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMode5:     mode5_q     <= cfg_data_i[0];
        CfgV30:       v30_q       <= cfg_data_i[0];
        CfgH40:       h40_q       <= cfg_data_i[0];
        CfgInterlace: interlace_q <= cfg_data_i[0];
        CfgPal:       pal_q       <= cfg_data_i[0];
        CfgExtSync:   ext_sync_q  <= cfg_data_i[0];
        CfgHsyncEn:   hsync_en_q  <= cfg_data_i[0];
        CfgTestSel:   test_sel_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcount_q      <= '0;
      vcount_q      <= '0;
      odd_q         <= 1'b0;
      sync_seen_q   <= '0;
      vsync_seen_q  <= '0;
      hmark_q       <= '0;
      hmark_early_q <= '0;
      hs_pin_q      <= 1'b0;
      cs_pin_q      <= 1'b0;
      pm_q          <= '0;
      ftrig_q       <= 1'b0;
      vs_q          <= 1'b0;
    end else if (accept) begin
      hcount_q      <= hcount_d;
      vcount_q      <= vcount_d;
      odd_q         <= odd_d;
      sync_seen_q   <= sync_seen_d;
      vsync_seen_q  <= vsync_seen_d;
      hmark_q       <= hmark_d;
      hmark_early_q <= hmark_early_d;
      hs_pin_q      <= it.hsync_pin_in;
      cs_pin_q      <= it.csync_pin_in;
      pm_q          <= pm_d;
      ftrig_q       <= ftrig_d;
      vs_q          <= vs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.hcount    <= hcount_d;
      out_q.vcount    <= vcount_d;
      out_q.odd_field <= odd_d;
      out_q.vsync_out <= vs_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid_q && !out_o.ready)
    else $error("input stalled without a held result");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && out_q.hcount == hcount_q && out_q.vcount == vcount_q
               && out_q.odd_field == odd_q && out_q.vsync_out == vs_q)
    else $error("result register out of step with counter state");

  a_reset_request_clears_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (it.reset_request || !interlace_q) |=> !odd_q)
    else $error("field bit set after reset request or with interlace off");

  a_hload_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && it.load_horizontal |=> hcount_q == $past(it.load_value))
    else $error("horizontal test load lost");

  a_reset_request_sets_vsync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && it.reset_request && !(pm_q.vsclr && gate) |=> vs_q)
    else $error("vsync flag not set by reset request");
`endif

endmodule
